>>> src/dds_waveform_generator_unit_macros.svh
// Assertion macros shared by the waveform generator RTL.
`ifndef DDS_WAVEFORM_GENERATOR_UNIT_MACROS_SVH
`define DDS_WAVEFORM_GENERATOR_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, disabled while reset is asserted.
`define DWG_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dwg assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define DWG_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dwg assertion failed");

`else

`define DWG_ASSERT_NOW(label, ante, cons)
`define DWG_ASSERT_NEXT(label, ante, cons)

`endif

`endif

>>> src/dwg_pkg.sv
// Package with types, constants and waveform tables of the waveform generator.
`timescale 1ns / 1ps
`default_nettype none

package dwg_pkg;

    // Default accumulator width and fixed field widths.
    localparam int unsigned DEFAULT_PHASE_WIDTH = 32;
    localparam int unsigned INDEX_WIDTH         = 8;
    localparam int unsigned SAMPLE_WIDTH        = 8;
    localparam int unsigned SELECT_WIDTH        = 3;
    localparam int unsigned CFG_INDEX_WIDTH     = 2;

    // Tuning word after reset.
    localparam logic [31:0] TUNING_RESET = 32'd8589934;

    // Register indexes of the configuration port.
    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        CFG_TUNING_WORD     = 2'd0,
        CFG_WAVEFORM_SELECT = 2'd1
    } cfg_reg_t;

    // Waveform selector codes.
    typedef enum logic [SELECT_WIDTH-1:0] {
        WAVE_SINE     = 3'd0,
        WAVE_COSINE   = 3'd1,
        WAVE_TRIANGLE = 3'd2,
        WAVE_SAWTOOTH = 3'd3,
        WAVE_REVERSE  = 3'd4,
        WAVE_SQUARE   = 3'd5
    } wave_sel_t;

    // First quarter of the sine wave, indices 0 through 64 inclusive.
    localparam logic [7:0] QUARTER_SINE [0:64] = '{
        8'd128, 8'd131, 8'd134, 8'd137, 8'd140, 8'd143, 8'd146, 8'd149, 8'd152, 8'd155,
        8'd158, 8'd162, 8'd165, 8'd167, 8'd170, 8'd173, 8'd176, 8'd179, 8'd182, 8'd185,
        8'd188, 8'd190, 8'd193, 8'd196, 8'd198, 8'd201, 8'd203, 8'd206, 8'd208, 8'd211,
        8'd213, 8'd215, 8'd218, 8'd220, 8'd222, 8'd224, 8'd226, 8'd228, 8'd230, 8'd232,
        8'd234, 8'd235, 8'd237, 8'd238, 8'd240, 8'd241, 8'd243, 8'd244, 8'd245, 8'd246,
        8'd248, 8'd249, 8'd250, 8'd250, 8'd251, 8'd252, 8'd253, 8'd253, 8'd254, 8'd254,
        8'd254, 8'd255, 8'd255, 8'd255, 8'd255
    };

    // Full sine period rebuilt from the quarter table by symmetry.
    function automatic logic [SAMPLE_WIDTH-1:0] dwg_sine_at(input logic [INDEX_WIDTH-1:0] i);
        logic       neg_half;
        logic [6:0] k;
        logic [6:0] j;
        logic [7:0] q;
        neg_half = i[7];
        k        = i[6:0];
        j        = (k <= 7'd64) ? k : 7'(8'd128 - {1'b0, k});
        q        = QUARTER_SINE[j];
        if (!neg_half)
            return q;
        else if (k == 7'd0)
            return 8'd128;
        else
            return ~q;
    endfunction

    // Sample of the selected waveform at one table index; unused codes give zero.
    function automatic logic [SAMPLE_WIDTH-1:0] dwg_table_value(
        input logic [SELECT_WIDTH-1:0] sel,
        input logic [INDEX_WIDTH-1:0]  i
    );
        logic [SAMPLE_WIDTH-1:0] value;
        case (sel)
            WAVE_SINE:     value = dwg_sine_at(i);
            WAVE_COSINE:   value = dwg_sine_at(i + 8'd64);
            WAVE_TRIANGLE: value = i[7] ? ~{i[6:0], 1'b0} : {i[6:0], 1'b0};
            WAVE_SAWTOOTH: value = i;
            WAVE_REVERSE:  value = ~i;
            WAVE_SQUARE:   value = i[7] ? 8'h00 : 8'hFF;
            default:       value = '0;
        endcase
        return value;
    endfunction

endpackage

`default_nettype wire

>>> src/dwg_tick_if.sv
// Handshake channel that carries sample tick words.
`timescale 1ns / 1ps
`default_nettype none

interface dwg_tick_if;
    logic valid;
    logic ready;
    logic sample_tick;

    modport source (output valid, output sample_tick, input ready);
    modport sink   (input valid, input sample_tick, output ready);
endinterface

`default_nettype wire

>>> src/dwg_sample_if.sv
// Handshake channel that carries generated sample words.
`timescale 1ns / 1ps
`default_nettype none

interface dwg_sample_if;
    import dwg_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [SAMPLE_WIDTH-1:0] sample_value;
    logic [INDEX_WIDTH-1:0]  table_index;

    modport source (output valid, output sample_value, output table_index, input ready);
    modport sink   (input valid, input sample_value, input table_index, output ready);
endinterface

`default_nettype wire

>>> src/dds_waveform_generator_unit.sv
// Top level of the direct digital synthesizer: phase accumulator, table lookup, output skid.
//
//  Channel   Direction  Carries
//  --------  ---------  -----------------------------------------------
//  tick      in         sample_tick (a word with tick low yields nothing)
//  samples   out        sample_value, table_index
//  cfg_*     in         register writes, no handshake
//
// The table lookup sits between the phase register and the output register, so one tick
// word is accepted per cycle while tick.ready is high.
// A result is registered in the output register, or in the skid register while samples stall.
// A two-entry output stage (output register plus skid register) keeps tick.ready high
// while one result waits; ready drops only when both entries are full.
// Reset clears the accumulator and the valid flags and loads the configuration defaults.
`timescale 1ns / 1ps
`default_nettype none

`include "dds_waveform_generator_unit_macros.svh"

module dds_waveform_generator_unit #(
    parameter int unsigned PHASE_WIDTH = dwg_pkg::DEFAULT_PHASE_WIDTH
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    dwg_tick_if.sink                                   tick,
    dwg_sample_if.source                               samples,
    input  wire logic                                  cfg_wr_en,
    input  wire logic [dwg_pkg::CFG_INDEX_WIDTH-1:0]   cfg_index,
    input  wire logic [PHASE_WIDTH-1:0]                cfg_wdata
);
    import dwg_pkg::*;

    // Configuration and accumulator state.
    logic [PHASE_WIDTH-1:0]  tuning_word_reg;
    logic [SELECT_WIDTH-1:0] wave_sel_reg;
    logic [PHASE_WIDTH-1:0]  phase_reg;

    // Output register and skid register.
    logic                    out_valid_reg;
    logic [SAMPLE_WIDTH-1:0] out_sample_reg;
    logic [INDEX_WIDTH-1:0]  out_index_reg;
    logic                    skid_valid_reg;
    logic [SAMPLE_WIDTH-1:0] skid_sample_reg;
    logic [INDEX_WIDTH-1:0]  skid_index_reg;

    logic                    in_ready;
    logic                    produce;
    logic                    out_free;
    logic [INDEX_WIDTH-1:0]  index_next;
    logic [SAMPLE_WIDTH-1:0] sample_next;

    // Handshake decode.
    assign in_ready  = !skid_valid_reg;
    assign produce   = tick.valid && in_ready && tick.sample_tick;
    assign out_free  = !out_valid_reg || samples.ready;

    // Table lookup on the top bits of the current phase.
    assign index_next  = phase_reg[PHASE_WIDTH-1 -: INDEX_WIDTH];
    assign sample_next = dwg_table_value(wave_sel_reg, index_next);

    // Port drive.
    assign tick.ready           = in_ready;
    assign samples.valid        = out_valid_reg;
    assign samples.sample_value = out_sample_reg;
    assign samples.table_index  = out_index_reg;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tuning_word_reg <= PHASE_WIDTH'(TUNING_RESET);
            wave_sel_reg    <= WAVE_SINE;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_TUNING_WORD:     tuning_word_reg <= cfg_wdata;
                CFG_WAVEFORM_SELECT: wave_sel_reg    <= cfg_wdata[SELECT_WIDTH-1:0];
                default:             ;
            endcase
        end
    end

    // Phase accumulator advances once per produced sample.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            phase_reg <= '0;
        else if (produce)
            phase_reg <= phase_reg + tuning_word_reg;
    end

    // Valid flags of the output and skid entries.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg  <= skid_valid_reg || produce;
            skid_valid_reg <= 1'b0;
        end
        else if (produce)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    // Payload of the output and skid entries.
    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_sample_reg <= skid_sample_reg;
                out_index_reg  <= skid_index_reg;
            end
            else if (produce)
            begin
                out_sample_reg <= sample_next;
                out_index_reg  <= index_next;
            end
        end
        else if (produce)
        begin
            skid_sample_reg <= sample_next;
            skid_index_reg  <= index_next;
        end
    end

    // The skid entry only fills behind a waiting output word.
    `DWG_ASSERT_NOW(a_skid_behind_out, skid_valid_reg, out_valid_reg)
    // A produced sample steps the phase by the tuning word.
    `DWG_ASSERT_NEXT(a_phase_step, produce, phase_reg == $past(phase_reg) + $past(tuning_word_reg))
    // Without a produced sample the phase holds.
    `DWG_ASSERT_NEXT(a_phase_hold, !produce, $stable(phase_reg))
    // A sample made while the output stalls lands in the skid entry.
    `DWG_ASSERT_NEXT(a_skid_catch, produce && !out_free, skid_valid_reg)

endmodule

`default_nettype wire
